[hdl/alhd_pkg.sv]
// Shared types and constants for the head-insert array list.
package alhd_pkg;

  localparam int CAPACITY   = 16;
  localparam int DUMP_LIMIT = 16;
  localparam int DUMP_N_MAX = (CAPACITY < DUMP_LIMIT) ? CAPACITY : DUMP_LIMIT;
  localparam int DATA_W     = 32;
  localparam int POS_W      = 5;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int PTR_W      = $clog2(CAPACITY);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_DUMP   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RESP,
    S_RM_RD,
    S_RM_CMP,
    S_DUMP_RD,
    S_DUMP_EMIT
  } state_t;

  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [PTR_W-1:0]  raddr;
  } ram_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [DATA_W-1:0] entry_value;
    logic [POS_W-1:0]  position;
    logic              last;
  } res_t;

  // Step a ring pointer forward, wrapping at capacity.
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
  endfunction

  // Step a ring pointer backward, wrapping at zero.
  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    ptr_dec = (p == '0) ? PTR_W'(CAPACITY - 1) : p - 1'b1;
  endfunction

endpackage

[hdl/alhd_ram.sv]
// Entry storage: one write port, one read port, registered read data.
module alhd_ram (
  input  logic                     clk,
  input  alhd_pkg::ram_req_t       req,
  output logic [alhd_pkg::DATA_W-1:0] rdata
);
  import alhd_pkg::*;

  logic [DATA_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Hold read data between reads.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

[hdl/alhd_ctrl.sv]
// Command sequencer: ring pointers, count, compaction and dump sweeps.
module alhd_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  logic [1:0]                  cmd_opcode,
  input  logic [alhd_pkg::DATA_W-1:0] cmd_value,
  output alhd_pkg::ram_req_t          ram_req,
  input  logic [alhd_pkg::DATA_W-1:0] ram_rdata,
  output logic                        emit_valid,
  input  logic                        emit_ok,
  output alhd_pkg::res_t              emit_data
);
  import alhd_pkg::*;

  state_t            state, state_next;
  logic [CNT_W-1:0]  count;
  logic [PTR_W-1:0]  head;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  kept;
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W-1:0]  wr_ptr;
  logic [DATA_W-1:0] value_r;
  status_t           status_r;

  logic              accept;
  opcode_t           op;
  logic              full;
  logic [CNT_W-1:0]  dump_n;
  logic              keep;
  logic [CNT_W-1:0]  kept_next;
  logic              sweep_end;
  logic              dump_last;

  assign op        = opcode_t'(cmd_opcode);
  assign accept    = cmd_valid && cmd_ready;
  assign full      = (count == CNT_W'(CAPACITY));
  assign dump_n    = (count > CNT_W'(DUMP_N_MAX)) ? CNT_W'(DUMP_N_MAX) : count;
  assign keep      = (ram_rdata != value_r);
  assign kept_next = kept + CNT_W'(keep);
  assign sweep_end = (idx + 1'b1 == count);
  assign dump_last = (idx + 1'b1 == dump_n);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_INSERT: state_next = S_RESP;
            OP_REMOVE: state_next = (count == '0) ? S_RESP : S_RM_RD;
            OP_DUMP:   state_next = (count == '0) ? S_RESP : S_DUMP_RD;
            OP_NONE:   state_next = S_IDLE;
          endcase
        end
      end
      S_RESP:      if (emit_ok) state_next = S_IDLE;
      S_RM_RD:     state_next = S_RM_CMP;
      S_RM_CMP:    state_next = sweep_end ? S_RESP : S_RM_RD;
      S_DUMP_RD:   state_next = S_DUMP_EMIT;
      S_DUMP_EMIT: begin
        if (emit_ok) state_next = dump_last ? S_IDLE : S_DUMP_RD;
      end
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready     = (state == S_IDLE) && !rst;
    ram_req       = '0;
    emit_valid    = 1'b0;
    emit_data     = '0;
    ram_req.wdata = cmd_value;
    unique case (state)
      S_IDLE: begin
        // Insert writes straight into the slot ahead of the head.
        ram_req.we    = accept && (op == OP_INSERT) && !full;
        ram_req.waddr = ptr_dec(head);
      end
      S_RESP: begin
        emit_valid       = 1'b1;
        emit_data.status = status_r;
        emit_data.last   = 1'b1;
      end
      S_RM_RD, S_DUMP_RD: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = rd_ptr;
      end
      S_RM_CMP: begin
        ram_req.we    = keep;
        ram_req.waddr = wr_ptr;
        ram_req.wdata = ram_rdata;
      end
      S_DUMP_EMIT: begin
        emit_valid            = 1'b1;
        emit_data.status      = ST_OK;
        emit_data.entry_value = ram_rdata;
        emit_data.position    = POS_W'(idx + 1'b1);
        emit_data.last        = dump_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      head  <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            value_r <= cmd_value;
            idx     <= '0;
            kept    <= '0;
            rd_ptr  <= head;
            wr_ptr  <= head;
            unique case (op)
              OP_INSERT: begin
                if (full) begin
                  status_r <= ST_FULL;
                end else begin
                  status_r <= ST_OK;
                  head     <= ptr_dec(head);
                  count    <= count + 1'b1;
                end
              end
              OP_REMOVE, OP_DUMP: status_r <= ST_EMPTY;
              OP_NONE:            status_r <= ST_OK;
            endcase
          end
        end
        S_RM_CMP: begin
          kept   <= kept_next;
          idx    <= idx + 1'b1;
          rd_ptr <= ptr_inc(rd_ptr);
          if (keep) wr_ptr <= ptr_inc(wr_ptr);
          if (sweep_end) begin
            if (kept_next == count) begin
              status_r <= ST_NOT_FOUND;
            end else begin
              status_r <= ST_OK;
              count    <= kept_next;
            end
          end
        end
        S_DUMP_EMIT: begin
          if (emit_ok) begin
            idx    <= idx + 1'b1;
            rd_ptr <= ptr_inc(rd_ptr);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[hdl/array_list_head_insert_delete_all_top.sv]
// Head-insert list: an insert or error result goes through the response state and is then registered at the output.
// Remove sweeps the ring in memory, a read state then a compare state per stored entry, then responds.
// Dump emits one result per entry (memory read, then emit), waiting while the output register is full.
// Next command is taken once the last result of the current one is registered.
// Synchronous reset empties the list (count and head); storage is not cleared.
module array_list_head_insert_delete_all_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // value
  input  logic [1:0]  s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // entry_value, position, zero pad
  output logic [1:0]  m_tuser,   // status
  output logic        m_tlast    // last
);
  import alhd_pkg::*;

  ram_req_t          ram_req;
  logic [DATA_W-1:0] ram_rdata;
  logic              emit_valid;
  logic              emit_ok;
  res_t              emit_data;
  res_t              out_r;
  logic              out_valid;

  alhd_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  alhd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (s_tvalid),
    .cmd_ready  (s_tready),
    .cmd_opcode (s_tuser),
    .cmd_value  (s_tdata),
    .ram_req    (ram_req),
    .ram_rdata  (ram_rdata),
    .emit_valid (emit_valid),
    .emit_ok    (emit_ok),
    .emit_data  (emit_data)
  );

  // Load a new result when the register is empty or being drained.
  assign emit_ok = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_valid && emit_ok) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid && emit_ok) begin
      out_r <= emit_data;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(40 - DATA_W - POS_W)'(0), out_r.position, out_r.entry_value};
  assign m_tuser  = out_r.status;
  assign m_tlast  = out_r.last;

endmodule
